// File: hdl/knn_pkg.sv
// Shared types, codes and the distance ordering for the nearest-neighbour search unit.
package knn_pkg;

  localparam logic [1:0] KIND_QUERY  = 2'd0;
  localparam logic [1:0] KIND_RECORD = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_SPARE  = 2'd3;

  localparam int RESULT_LIMIT = 16;
  localparam logic [47:0] DIST_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] value;
    logic signed [31:0] id;
    logic               last;
  } item_t;

  typedef struct packed {
    logic signed [31:0] id;
    logic [47:0]        distance;
    logic [3:0]         rank;
    logic               found;
    logic               length_error;
    logic               last;
  } result_t;

  // True when (da, ia) orders after (db, ib): by distance, then by signed id.
  function automatic logic after(input logic [47:0] da, input logic signed [31:0] ia,
                                 input logic [47:0] db, input logic signed [31:0] ib);
    if (da != db) begin
      return da > db;
    end
    return ia > ib;
  endfunction

endpackage

// File: hdl/knn_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module knn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/knn_front.sv
// Front end: accepts input transfers, drops reserved kinds and queues the rest.
module knn_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  knn_pkg::item_t in_item,
  output logic          q_valid,
  output knn_pkg::item_t q_item,
  input  logic          q_pop
);
  import knn_pkg::*;

  item_t      fifo [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] cnt;
  logic       push;

  assign in_stall = (cnt == 3'd4);
  assign push     = in_valid && !in_stall && (in_item.kind != KIND_SPARE);
  assign q_valid  = (cnt != 3'd0);
  assign q_item   = fifo[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wp] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 2'd1;
      end
      if (q_pop) begin
        rp <= rp + 2'd1;
      end
      cnt <= cnt + {2'b0, push} - {2'b0, q_pop};
    end
  end

endmodule

// File: hdl/knn_back.sv
// Back end: query load, distance accumulation, top-k upkeep and sorted answer output.
module knn_back #(
  parameter int MAX_DIMENSION = 256,
  parameter int MAX_NEIGHBORS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [4:0]       neighbor_count,
  input  logic             q_valid,
  input  knn_pkg::item_t   q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output knn_pkg::result_t out_result
);
  import knn_pkg::*;

  localparam int PW  = $clog2(MAX_DIMENSION + 1);
  localparam int QAW = MAX_DIMENSION > 1 ? $clog2(MAX_DIMENSION) : 1;
  localparam int CW  = $clog2(MAX_NEIGHBORS + 1);
  localparam int IW  = MAX_NEIGHBORS > 1 ? $clog2(MAX_NEIGHBORS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_KEEP  = 3'd3;
  localparam logic [2:0] S_WORST = 3'd4;
  localparam logic [2:0] S_SORT  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;
  localparam logic [2:0] S_EMPTY = 3'd7;

  logic [2:0]         state;
  logic [PW-1:0]      qlen;
  logic [PW-1:0]      pos;
  logic [47:0]        acc;
  logic signed [31:0] cur_id;
  logic [CW-1:0]      kcount;
  logic               err;
  logic               loading;
  item_t              cur;
  logic [33:0]        sq;
  logic [47:0]        cand_d;
  logic               empty_err;
  logic [4:0]         rank_r;
  logic [4:0]         n_r;
  logic [MAX_NEIGHBORS-1:0] used;

  // Scan over the kept entries, one read per cycle.
  logic [CW-1:0]      scan_idx;
  logic               dv;
  logic [IW-1:0]      dv_idx;
  logic               have;
  logic [47:0]        best_d;
  logic signed [31:0] best_id;
  logic [IW-1:0]      best_idx;

  logic [15:0]        q_rdata;
  logic [79:0]        k_rdata;
  logic               q_we;
  logic               k_we;
  logic [IW-1:0]      k_waddr;
  logic [79:0]        k_wdata;

  logic [7:0]         k8;
  logic [7:0]         c8;
  logic [7:0]         n8;
  logic               issue;
  logic               done;
  logic               consider;
  logic               better;
  logic signed [16:0] diff;
  logic [48:0]        sum;
  logic [47:0]        acc_sat;
  logic [PW-1:0]      pos_inc;
  logic               out_free;
  logic               pop_now;
  logic               load_out;

  knn_ram #(.WIDTH(16), .DEPTH(MAX_DIMENSION)) u_query_ram (
    .clk  (clk),
    .we   (q_we),
    .waddr(qlen[QAW-1:0]),
    .wdata(q_item.value),
    .raddr(pos[QAW-1:0]),
    .rdata(q_rdata)
  );

  knn_ram #(.WIDTH(80), .DEPTH(MAX_NEIGHBORS)) u_kept_ram (
    .clk  (clk),
    .we   (k_we),
    .waddr(k_waddr),
    .wdata(k_wdata),
    .raddr(scan_idx[IW-1:0]),
    .rdata(k_rdata)
  );

  always_comb begin
    k8 = ({3'b0, neighbor_count} > 8'(MAX_NEIGHBORS)) ? 8'(MAX_NEIGHBORS)
                                                     : {3'b0, neighbor_count};
    c8 = 8'(kcount);
    n8 = (c8 < k8) ? c8 : k8;
    if (n8 > 8'(RESULT_LIMIT)) begin
      n8 = 8'(RESULT_LIMIT);
    end
  end

  assign pop_now  = (state == S_IDLE) && q_valid;
  assign q_pop    = pop_now;
  assign q_we     = pop_now && (q_item.kind == KIND_QUERY) && loading &&
                    (qlen < PW'(MAX_DIMENSION));
  assign out_free = !out_valid || !out_stall;
  assign load_out = ((state == S_EMIT) || (state == S_EMPTY)) && out_free;

  assign issue    = (scan_idx < kcount);
  assign done     = !issue && !dv;
  assign consider = dv && ((state != S_SORT) || !used[dv_idx]);
  assign better   = !have ||
                    ((state == S_WORST) ? after(k_rdata[79:32], k_rdata[31:0], best_d, best_id)
                                        : after(best_d, best_id, k_rdata[79:32], k_rdata[31:0]));

  assign diff     = {cur.value[15], cur.value} - {q_rdata[15], q_rdata};
  assign sum      = {1'b0, acc} + {15'b0, sq};
  assign acc_sat  = sum[48] ? DIST_MAX : sum[47:0];
  assign pos_inc  = pos + PW'(1);

  always_comb begin
    k_we    = 1'b0;
    k_waddr = kcount[IW-1:0];
    k_wdata = {cand_d, cur_id};
    if (state == S_KEEP && c8 < k8) begin
      k_we = 1'b1;
    end else if (state == S_WORST && done && cand_d < best_d) begin
      k_we    = 1'b1;
      k_waddr = best_idx;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (pop_now) begin
      cur <= q_item;
    end
    if (state == S_MUL) begin
      sq <= unsigned'(34'(diff) * 34'(diff));
    end
    if (state == S_ACC) begin
      cand_d <= acc_sat;
    end
    dv_idx <= scan_idx[IW-1:0];
    if (consider && better) begin
      best_d   <= k_rdata[79:32];
      best_id  <= k_rdata[31:0];
      best_idx <= dv_idx;
    end
    if (state == S_EMIT && out_free) begin
      out_result.id           <= best_id;
      out_result.distance     <= best_d;
      out_result.rank         <= rank_r[3:0];
      out_result.found        <= 1'b1;
      out_result.length_error <= 1'b0;
      out_result.last         <= (rank_r + 5'd1) == n_r;
    end else if (state == S_EMPTY && out_free) begin
      out_result.id           <= '0;
      out_result.distance     <= '0;
      out_result.rank         <= '0;
      out_result.found        <= 1'b0;
      out_result.length_error <= empty_err;
      out_result.last         <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      qlen      <= '0;
      pos       <= '0;
      acc       <= '0;
      cur_id    <= '0;
      kcount    <= '0;
      err       <= 1'b0;
      loading   <= 1'b1;
      empty_err <= 1'b0;
      rank_r    <= '0;
      n_r       <= '0;
      used      <= '0;
      scan_idx  <= '0;
      dv        <= 1'b0;
      have      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= load_out || (out_valid && out_stall);
      if (state == S_WORST || state == S_SORT) begin
        dv <= issue;
        if (issue) begin
          scan_idx <= scan_idx + CW'(1);
        end
        if (consider && better) begin
          have <= 1'b1;
        end
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            case (q_item.kind)
              KIND_QUERY: begin
                if (loading) begin
                  if (qlen < PW'(MAX_DIMENSION)) begin
                    qlen <= qlen + PW'(1);
                  end
                  if (q_item.last) begin
                    loading <= 1'b0;
                  end
                end
              end
              KIND_RECORD: begin
                if (!loading && !err) begin
                  if (pos == '0) begin
                    cur_id <= q_item.id;
                  end
                  if (pos >= qlen) begin
                    err <= 1'b1;
                    pos <= '0;
                    acc <= '0;
                  end else begin
                    state <= S_MUL;
                  end
                end
              end
              KIND_END: begin
                if (err || loading || n8 == 8'd0) begin
                  empty_err <= err && !loading;
                  state     <= S_EMPTY;
                end else begin
                  n_r      <= n8[4:0];
                  rank_r   <= '0;
                  used     <= '0;
                  scan_idx <= '0;
                  dv       <= 1'b0;
                  have     <= 1'b0;
                  state    <= S_SORT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (cur.last) begin
            pos <= '0;
            acc <= '0;
            if (pos_inc != qlen) begin
              err   <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_KEEP;
            end
          end else begin
            acc   <= acc_sat;
            pos   <= pos_inc;
            state <= S_IDLE;
          end
        end
        S_KEEP: begin
          if (c8 < k8) begin
            kcount <= kcount + CW'(1);
            state  <= S_IDLE;
          end else if (kcount == '0) begin
            state <= S_IDLE;
          end else begin
            scan_idx <= '0;
            dv       <= 1'b0;
            have     <= 1'b0;
            state    <= S_WORST;
          end
        end
        S_WORST: begin
          if (done) begin
            state <= S_IDLE;
          end
        end
        S_SORT: begin
          if (done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            used[best_idx] <= 1'b1;
            if ((rank_r + 5'd1) == n_r) begin
              qlen    <= '0;
              pos     <= '0;
              acc     <= '0;
              cur_id  <= '0;
              kcount  <= '0;
              err     <= 1'b0;
              loading <= 1'b1;
              state   <= S_IDLE;
            end else begin
              rank_r   <= rank_r + 5'd1;
              scan_idx <= '0;
              dv       <= 1'b0;
              have     <= 1'b0;
              state    <= S_SORT;
            end
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            qlen      <= '0;
            pos       <= '0;
            acc       <= '0;
            cur_id    <= '0;
            kcount    <= '0;
            err       <= 1'b0;
            loading   <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/top_k_nearest_l2_search_unit.sv
// Top level of the exact k-nearest-neighbour search unit by squared L2 distance.
//
// Input channel (in_valid / in_stall): one transfer per element. Kind query
// loads the query vector, kind record streams a record's elements, kind end
// closes the dataset and produces the answer. Reserved kinds are dropped.
// A four-entry queue parts the input from the execution engine, so the
// input is stalled only while that queue is full.
// Output channel (out_valid / out_stall): the kept records nearest first,
// or a single empty or length-error result, the final one marked last_result.
// Steps in the engine: a query element is popped in the idle state; a record
// element goes through query memory read, square and accumulate. A record's
// last element adds a keep step, plus a worst-entry scan of the kept memory
// once the set is full. Each answer result takes a scan over the kept memory
// and a load of the output register; an empty or error answer takes only the
// load. An output stall holds the engine once the output register is occupied.
// neighbor_count is written through cfg_write_enable / cfg_write_data and
// resets to one. Reset empties the queue, drops any output and returns the
// engine to query loading; memory contents are not cleared.
module top_k_nearest_l2_search_unit #(
  parameter int MAX_DIMENSION = 256,
  parameter int MAX_NEIGHBORS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_enable,
  input  logic [4:0]         cfg_write_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic signed [15:0] element_value,
  input  logic signed [31:0] record_id,
  input  logic               vector_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] neighbor_id,
  output logic [47:0]        neighbor_distance,
  output logic [3:0]         rank,
  output logic               found,
  output logic               length_error,
  output logic               last_result
);
  import knn_pkg::*;

  logic [4:0] neighbor_count;
  item_t      in_item;
  item_t      q_item;
  logic       q_valid;
  logic       q_pop;
  result_t    res;

  always_ff @(posedge clk) begin
    if (rst) begin
      neighbor_count <= 5'd1;
    end else if (cfg_write_enable) begin
      neighbor_count <= cfg_write_data;
    end
  end

  assign in_item.kind  = kind;
  assign in_item.value = element_value;
  assign in_item.id    = record_id;
  assign in_item.last  = vector_last;

  knn_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  knn_back #(
    .MAX_DIMENSION(MAX_DIMENSION),
    .MAX_NEIGHBORS(MAX_NEIGHBORS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .neighbor_count(neighbor_count),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_result    (res)
  );

  assign neighbor_id       = res.id;
  assign neighbor_distance = res.distance;
  assign rank              = res.rank;
  assign found             = res.found;
  assign length_error      = res.length_error;
  assign last_result       = res.last;

  // An empty or error result is always a single, final transfer.
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> last_result)
    else $error("empty result not marked last");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> neighbor_id == 0 && neighbor_distance == 0 && rank == 0)
    else $error("empty result carries data");

  a_found_no_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> !length_error)
    else $error("neighbour result flagged as length error");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule
